FILE: hw/rtl/pcmt_pkg.sv
// Shared widths, codes and types of the compare timer.
`timescale 1ns / 1ps

package pcmt_pkg;

   localparam int TIME_W   = 64;
   localparam int FREQ_W   = 32;
   localparam int ARG_W    = 32;
   localparam int ACTION_W = 2;

   localparam logic [FREQ_W-1:0] FREQ_RESET       = 32'd10000000;
   localparam logic [FREQ_W-1:0] MS_PER_SEC       = 32'd1000;
   localparam logic [ARG_W-1:0]  NS_PER_SEC       = 32'd1000000000;
   localparam logic [TIME_W-1:0] DEADLINE_DISARMED = {TIME_W{1'b1}};

   typedef enum logic [ACTION_W-1:0] {
      ACT_TICK     = 2'd0,
      ACT_ONESHOT  = 2'd1,
      ACT_PERIODIC = 2'd2,
      ACT_READ     = 2'd3
   } action_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

endpackage

FILE: hw/rtl/pcmt_if.sv
// Valid/ready channels of the compare timer: request, response and register write.
`timescale 1ns / 1ps

interface pcmt_req_if;
   logic                         valid;
   logic                         ready;
   logic [pcmt_pkg::ACTION_W-1:0] action;
   logic [pcmt_pkg::ARG_W-1:0]   argument;

   modport source (output valid, action, argument, input ready);
   modport sink (input valid, action, argument, output ready);
endinterface

interface pcmt_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       irq_fired;
   logic [pcmt_pkg::TIME_W-1:0] tick_total;
   logic [pcmt_pkg::TIME_W-1:0] time_ns;

   modport source (output valid, irq_fired, tick_total, time_ns, input ready);
   modport sink (input valid, irq_fired, tick_total, time_ns, output ready);
endinterface

interface pcmt_csr_if;
   logic                       valid;
   logic                       ready;
   logic [pcmt_pkg::FREQ_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

FILE: hw/rtl/pcmt_serial_div.sv
// Restoring divider that retires one quotient bit per cycle.
`timescale 1ns / 1ps

module pcmt_serial_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [pcmt_pkg::TIME_W-1:0]   dividend,
   input  logic [pcmt_pkg::FREQ_W-1:0]   divisor,
   output logic [pcmt_pkg::TIME_W-1:0]   quotient,
   output logic [pcmt_pkg::FREQ_W-1:0]   remainder,
   output pcmt_pkg::unit_status_type     status
);
   import pcmt_pkg::*;

   localparam int STEPS = TIME_W;
   localparam int CNT_W = $clog2(STEPS);

   logic [TIME_W-1:0] quo_ff, quo_in;
   logic [FREQ_W-1:0] rem_ff, rem_in;
   logic [FREQ_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [FREQ_W:0]   rem_shift;
   logic [FREQ_W:0]   rem_diff;
   logic              fits;

   always_comb begin
      rem_shift = {rem_ff, quo_ff[TIME_W-1]};
      rem_diff  = rem_shift - {1'b0, den_ff};
      fits      = rem_shift >= {1'b0, den_ff};
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[TIME_W-2:0], fits};
         rem_in = fits ? rem_diff[FREQ_W-1:0] : rem_shift[FREQ_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient    = quo_ff;
   assign remainder   = rem_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

FILE: hw/rtl/pcmt_serial_mul.sv
// Shift-and-add multiplier that consumes one multiplier bit per cycle, product modulo 2^64.
`timescale 1ns / 1ps

module pcmt_serial_mul (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [pcmt_pkg::TIME_W-1:0]   multiplicand,
   input  logic [pcmt_pkg::ARG_W-1:0]    multiplier,
   output logic [pcmt_pkg::TIME_W-1:0]   product,
   output pcmt_pkg::unit_status_type     status
);
   import pcmt_pkg::*;

   localparam int STEPS = ARG_W;
   localparam int CNT_W = $clog2(STEPS);

   logic [TIME_W-1:0] acc_ff, acc_in;
   logic [TIME_W-1:0] mcand_ff, mcand_in;
   logic [ARG_W-1:0]  mplier_ff, mplier_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   always_comb begin
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         acc_in    = '0;
         mcand_in  = multiplicand;
         mplier_in = multiplier;
         cnt_in    = '0;
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         acc_in    = acc_ff + (mplier_ff[0] ? mcand_ff : '0);
         mcand_in  = {mcand_ff[TIME_W-2:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[ARG_W-1:1]};
         cnt_in    = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      cnt_ff    <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign product     = acc_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

FILE: hw/rtl/periodic_oneshot_compare_timer_unit.sv
// Top level of the compare timer: sequencer, timer state and response register.
`timescale 1ns / 1ps

// The block keeps a 64-bit time counter and a compare deadline and takes one request beat at
// a time. A tick passes through S_TICK and S_FINISH before its response is registered. A
// periodic arm uses the shared bit-serial divider, a one-shot arm the divider and then the
// shared bit-serial multiplier, and a time read the divider, the multiplier twice and the
// divider again. Arming with zero skips the arithmetic, and so does reading at a counter
// frequency of zero. A finished response waits in an output register, and the next request
// is taken while it waits. The frequency register may be written at any time the block is
// idle and is always ready.

module periodic_oneshot_compare_timer_unit (
   input logic       clock,
   input logic       reset,
   pcmt_req_if.sink   req_ch,
   pcmt_rsp_if.source rsp_ch,
   pcmt_csr_if.sink   csr_ch
);
   import pcmt_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_TICK,
      S_OS_DIV,
      S_OS_MUL,
      S_PER_DIV,
      S_RD_WDIV,
      S_RD_WMUL,
      S_RD_PMUL,
      S_RD_PDIV,
      S_RD_MAX,
      S_FINISH
   } state_type;

   state_type         state_ff, state_in;
   logic [ARG_W-1:0]  arg_ff, arg_in;
   logic [FREQ_W-1:0] part_ff, part_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic              fired_ff, fired_in;
   logic [TIME_W-1:0] ns_ff, ns_in;
   logic [TIME_W-1:0] time_ff, time_in;
   logic [TIME_W-1:0] deadline_ff, deadline_in;
   logic [TIME_W-1:0] reload_ff, reload_in;
   logic [TIME_W-1:0] expiry_ff, expiry_in;
   logic [TIME_W-1:0] last_read_ff, last_read_in;
   logic [FREQ_W-1:0] freq_ff, freq_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_irq_ff, rsp_irq_in;
   logic [TIME_W-1:0] rsp_total_ff, rsp_total_in;
   logic [TIME_W-1:0] rsp_ns_ff, rsp_ns_in;

   logic              div_start;
   logic [TIME_W-1:0] div_num;
   logic [FREQ_W-1:0] div_den;
   logic [TIME_W-1:0] div_quo;
   logic [FREQ_W-1:0] div_rem;
   unit_status_type   div_status;
   logic              mul_start;
   logic [TIME_W-1:0] mul_mcand;
   logic [ARG_W-1:0]  mul_mplier;
   logic [TIME_W-1:0] mul_prod;
   unit_status_type   mul_status;
   logic [TIME_W-1:0] reload_step;
   logic [TIME_W-1:0] oneshot_step;
   logic [TIME_W-1:0] periodic_step;
   logic              req_fire;

   pcmt_serial_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_num),
      .divisor   (div_den),
      .quotient  (div_quo),
      .remainder (div_rem),
      .status    (div_status)
   );

   pcmt_serial_mul u_mul (
      .clock        (clock),
      .reset        (reset),
      .start        (mul_start),
      .multiplicand (mul_mcand),
      .multiplier   (mul_mplier),
      .product      (mul_prod),
      .status       (mul_status)
   );

   assign req_fire      = req_ch.valid && (state_ff == S_IDLE);
   assign reload_step   = (reload_ff == '0) ? TIME_W'(1) : reload_ff;
   assign oneshot_step  = (mul_prod == '0) ? TIME_W'(1) : mul_prod;
   assign periodic_step = (div_quo == '0) ? TIME_W'(1) : div_quo;

   always_comb begin
      state_in     = state_ff;
      arg_in       = arg_ff;
      part_in      = part_ff;
      now_in       = now_ff;
      fired_in     = fired_ff;
      ns_in        = ns_ff;
      time_in      = time_ff;
      deadline_in  = deadline_ff;
      reload_in    = reload_ff;
      expiry_in    = expiry_ff;
      last_read_in = last_read_ff;
      freq_in      = freq_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_irq_in   = rsp_irq_ff;
      rsp_total_in = rsp_total_ff;
      rsp_ns_in    = rsp_ns_ff;
      div_start    = 1'b0;
      div_num      = {{(TIME_W-FREQ_W){1'b0}}, freq_ff};
      div_den      = freq_ff;
      mul_start    = 1'b0;
      mul_mcand    = div_quo;
      mul_mplier   = NS_PER_SEC;

      if (csr_ch.valid) begin
         freq_in = csr_ch.data;
      end
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               arg_in   = req_ch.argument;
               fired_in = 1'b0;
               ns_in    = '0;
               unique case (action_type'(req_ch.action))
                  ACT_TICK: begin
                     time_in  = time_ff + TIME_W'(1);
                     state_in = S_TICK;
                  end
                  ACT_ONESHOT: begin
                     if (req_ch.argument == '0) begin
                        deadline_in = DEADLINE_DISARMED;
                        state_in    = S_FINISH;
                     end else begin
                        div_start = 1'b1;
                        div_den   = MS_PER_SEC;
                        state_in  = S_OS_DIV;
                     end
                  end
                  ACT_PERIODIC: begin
                     if (req_ch.argument == '0) begin
                        deadline_in = DEADLINE_DISARMED;
                        state_in    = S_FINISH;
                     end else begin
                        div_start = 1'b1;
                        div_den   = req_ch.argument;
                        state_in  = S_PER_DIV;
                     end
                  end
                  ACT_READ: begin
                     if (freq_ff == '0) begin
                        now_in   = '0;
                        state_in = S_RD_MAX;
                     end else begin
                        div_start = 1'b1;
                        div_num   = time_ff;
                        state_in  = S_RD_WDIV;
                     end
                  end
                  default: begin
                     state_in = S_FINISH;
                  end
               endcase
            end
         end
         S_TICK: begin
            if (time_ff >= deadline_ff) begin
               expiry_in   = expiry_ff + TIME_W'(1);
               deadline_in = time_ff + reload_step;
               fired_in    = 1'b1;
            end
            state_in = S_FINISH;
         end
         S_OS_DIV: begin
            if (div_status.done) begin
               mul_start  = 1'b1;
               mul_mcand  = div_quo;
               mul_mplier = arg_ff;
               state_in   = S_OS_MUL;
            end
         end
         S_OS_MUL: begin
            if (mul_status.done) begin
               deadline_in = time_ff + oneshot_step;
               state_in    = S_FINISH;
            end
         end
         S_PER_DIV: begin
            if (div_status.done) begin
               reload_in   = periodic_step;
               deadline_in = time_ff + periodic_step;
               state_in    = S_FINISH;
            end
         end
         S_RD_WDIV: begin
            if (div_status.done) begin
               part_in   = div_rem;
               mul_start = 1'b1;
               mul_mcand = div_quo;
               state_in  = S_RD_WMUL;
            end
         end
         S_RD_WMUL: begin
            if (mul_status.done) begin
               now_in    = mul_prod;
               mul_start = 1'b1;
               mul_mcand = {{(TIME_W-FREQ_W){1'b0}}, part_ff};
               state_in  = S_RD_PMUL;
            end
         end
         S_RD_PMUL: begin
            if (mul_status.done) begin
               div_start = 1'b1;
               div_num   = mul_prod;
               state_in  = S_RD_PDIV;
            end
         end
         S_RD_PDIV: begin
            if (div_status.done) begin
               now_in   = now_ff + div_quo;
               state_in = S_RD_MAX;
            end
         end
         S_RD_MAX: begin
            if (now_ff > last_read_ff) begin
               last_read_in = now_ff;
               ns_in        = now_ff;
            end else begin
               ns_in = last_read_ff;
            end
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_irq_in   = fired_ff;
               rsp_total_in = expiry_ff;
               rsp_ns_in    = ns_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      arg_ff       <= arg_in;
      part_ff      <= part_in;
      now_ff       <= now_in;
      fired_ff     <= fired_in;
      ns_ff        <= ns_in;
      rsp_irq_ff   <= rsp_irq_in;
      rsp_total_ff <= rsp_total_in;
      rsp_ns_ff    <= rsp_ns_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         time_ff      <= '0;
         deadline_ff  <= DEADLINE_DISARMED;
         reload_ff    <= '0;
         expiry_ff    <= '0;
         last_read_ff <= '0;
         freq_ff      <= FREQ_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         time_ff      <= time_in;
         deadline_ff  <= deadline_in;
         reload_ff    <= reload_in;
         expiry_ff    <= expiry_in;
         last_read_ff <= last_read_in;
         freq_ff      <= freq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ch.ready      = (state_ff == S_IDLE);
   assign csr_ch.ready      = 1'b1;
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.irq_fired  = rsp_irq_ff;
   assign rsp_ch.tick_total = rsp_total_ff;
   assign rsp_ch.time_ns    = rsp_ns_ff;

   a_units_exclusive : assert property (@(posedge clock) disable iff (reset)
      $onehot0({div_status.busy, mul_status.busy}))
      else $error("Divider and multiplier are busy at the same time.");

   a_read_monotonic : assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> last_read_ff >= $past(last_read_ff))
      else $error("The last read time went backwards.");

   a_expiry_only_on_tick : assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_TICK) |=> expiry_ff == $past(expiry_ff))
      else $error("The expiry count changed outside a tick.");

   a_response_from_finish : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FINISH))
      else $error("A response beat appeared without a finished request.");

endmodule

FILE: tb/sv/compare_timer_checker.sv
`timescale 1ns / 1ps
// Checker of the compare timer: keeps its own copy of the timer state and checks every response.

module compare_timer_checker (
   input  logic clock,
   input  logic reset,
   pcmt_req_if  req_ch,
   pcmt_rsp_if  rsp_ch,
   pcmt_csr_if  csr_ch,
   output int   mismatches,
   output int   reports_due
);
   import pcmt_pkg::*;

   typedef struct packed {
      logic              irq_fired;
      logic [TIME_W-1:0] tick_total;
      logic [TIME_W-1:0] time_ns;
   } timer_report_type;

   logic [FREQ_W-1:0] freq_hz;
   logic [TIME_W-1:0] now_count;
   logic [TIME_W-1:0] deadline;
   logic [TIME_W-1:0] reload_interval;
   logic [TIME_W-1:0] expiries;
   logic [TIME_W-1:0] last_ns;
   timer_report_type  timer_reports[$];

   function automatic logic [TIME_W-1:0] count_to_ns(logic [TIME_W-1:0] count);
      logic [TIME_W-1:0] f;
      logic [TIME_W-1:0] whole;
      logic [TIME_W-1:0] part;
      f = TIME_W'(freq_hz);
      if (f == '0) return '0;
      whole = count / f;
      part  = count % f;
      return whole * TIME_W'(NS_PER_SEC) + (part * TIME_W'(NS_PER_SEC)) / f;
   endfunction

   function automatic timer_report_type advance_timer(action_type act, logic [ARG_W-1:0] arg);
      timer_report_type  report;
      logic [TIME_W-1:0] interval;
      logic [TIME_W-1:0] ns_now;
      report = '0;
      case (act)
         ACT_TICK: begin
            now_count = now_count + 64'd1;
            if (now_count >= deadline) begin
               expiries = expiries + 64'd1;
               interval = (reload_interval == '0) ? 64'd1 : reload_interval;
               deadline = now_count + interval;
               report.irq_fired = 1'b1;
            end
         end
         ACT_ONESHOT: begin
            if (arg == '0) begin
               deadline = DEADLINE_DISARMED;
            end else begin
               interval = TIME_W'(arg) * TIME_W'(freq_hz / MS_PER_SEC);
               if (interval == '0) interval = 64'd1;
               deadline = now_count + interval;
            end
         end
         ACT_PERIODIC: begin
            if (arg == '0) begin
               deadline = DEADLINE_DISARMED;
            end else begin
               interval = TIME_W'(freq_hz / arg);
               if (interval == '0) interval = 64'd1;
               reload_interval = interval;
               deadline = now_count + interval;
            end
         end
         default: begin
            ns_now = count_to_ns(now_count);
            if (ns_now > last_ns) last_ns = ns_now;
            report.time_ns = last_ns;
         end
      endcase
      report.tick_total = expiries;
      return report;
   endfunction

   task automatic check_field(string field, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", field, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      timer_report_type due;
      if (reset) begin
         freq_hz         = FREQ_RESET;
         now_count       = '0;
         deadline        = DEADLINE_DISARMED;
         reload_interval = '0;
         expiries        = '0;
         last_ns         = '0;
         mismatches      = 0;
         timer_reports.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (timer_reports.size() == 0) begin
               $error("response beat arrived with no request outstanding");
               mismatches++;
            end else begin
               due = timer_reports.pop_front();
               check_field("irq_fired", TIME_W'(due.irq_fired), TIME_W'(rsp_ch.irq_fired));
               check_field("tick_total", due.tick_total, rsp_ch.tick_total);
               check_field("time_ns", due.time_ns, rsp_ch.time_ns);
            end
         end
         if (csr_ch.valid && csr_ch.ready) freq_hz = csr_ch.data;
         if (req_ch.valid && req_ch.ready)
            timer_reports.push_back(advance_timer(action_type'(req_ch.action), req_ch.argument));
      end
      reports_due <= timer_reports.size();
   end

endmodule

FILE: tb/sv/tb_periodic_oneshot_compare_timer_unit.sv
`timescale 1ns / 1ps
// Top of the compare timer testbench: clock, reset, request and register stimulus, and verdict.

module tb_periodic_oneshot_compare_timer_unit;
   import pcmt_pkg::*;

   localparam int ITEMS_PER_PHASE   = 316;
   localparam int STALL_HOLD_CYCLES = 400;

   logic              clock;
   logic              reset;
   int                tx_idle_pct;
   int                rx_idle_pct;
   int                mismatches;
   int                reports_due;
   bit                hold_request;
   int                hold_left;
   logic [FREQ_W-1:0] cur_freq;
   logic [FREQ_W-1:0] phase_freq[6];

   pcmt_req_if req_ch ();
   pcmt_rsp_if rsp_ch ();
   pcmt_csr_if csr_ch ();

   periodic_oneshot_compare_timer_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   compare_timer_checker report_check (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_ch      (csr_ch),
      .mismatches  (mismatches),
      .reports_due (reports_due)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // The receiver counts its own long hold-off so that the block fills up and stalls requests.
   initial begin
      rsp_ch.ready = 1'b0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = STALL_HOLD_CYCLES;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   task automatic offer_item(action_type act, logic [ARG_W-1:0] arg);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.action   <= act;
      req_ch.argument <= arg;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   task automatic write_freq(logic [FREQ_W-1:0] value);
      req_ch.valid <= 1'b0;
      wait (reports_due == 0);
      repeat (4) @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
      cur_freq = value;
   endtask

   task automatic offer_random_item();
      int               pick;
      int               shape;
      logic [ARG_W-1:0] arg;
      pick  = $urandom_range(99);
      shape = $urandom_range(9);
      if (pick < 50) begin
         offer_item(ACT_TICK, $urandom);
      end else if (pick < 62) begin
         if (shape == 0) arg = '0;
         else if (shape < 3) arg = $urandom;
         else if (cur_freq < 12) arg = $urandom_range(1, 8);
         else arg = cur_freq / $urandom_range(1, 12);
         offer_item(ACT_PERIODIC, arg);
      end else if (pick < 72) begin
         if (shape == 0) arg = '0;
         else if (shape < 3) arg = $urandom;
         else arg = $urandom_range(1, 4);
         offer_item(ACT_ONESHOT, arg);
      end else begin
         offer_item(ACT_READ, $urandom);
      end
   endtask

   initial begin
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.action   = ACT_TICK;
      req_ch.argument = '0;
      csr_ch.valid    = 1'b0;
      csr_ch.data     = '0;
      hold_request    = 1'b0;
      tx_idle_pct     = 25;
      rx_idle_pct     = 85;
      cur_freq        = FREQ_RESET;
      phase_freq      = '{32'hFFFF_FFFF, 32'd0, 32'd7, 32'd2500, FREQ_RESET, 32'd0};
      phase_freq[5]   = $urandom;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      offer_item(ACT_READ, 32'd0);
      offer_item(ACT_TICK, 32'hFFFF_FFFF);
      offer_item(ACT_READ, 32'hFFFF_FFFF);
      offer_item(ACT_PERIODIC, 32'hFFFF_FFFF);
      offer_item(ACT_TICK, 32'd0);
      offer_item(ACT_TICK, 32'd0);
      offer_item(ACT_PERIODIC, 32'd3333333);
      repeat (3) offer_item(ACT_TICK, 32'd0);
      offer_item(ACT_ONESHOT, 32'd0);
      offer_item(ACT_TICK, 32'd0);
      offer_item(ACT_ONESHOT, 32'hFFFF_FFFF);
      offer_item(ACT_TICK, 32'd0);
      offer_item(ACT_ONESHOT, 32'd1);
      offer_item(ACT_PERIODIC, 32'd0);
      offer_item(ACT_READ, 32'd0);

      write_freq(32'd0);
      offer_item(ACT_READ, 32'd0);
      offer_item(ACT_PERIODIC, 32'd5);
      offer_item(ACT_TICK, 32'd0);
      offer_item(ACT_ONESHOT, 32'd7);
      offer_item(ACT_TICK, 32'd0);

      write_freq(32'd999);
      offer_item(ACT_ONESHOT, 32'd2);
      offer_item(ACT_TICK, 32'd0);
      offer_item(ACT_READ, 32'd0);

      for (int phase = 0; phase < 6; phase++) begin
         write_freq(phase_freq[phase]);
         case (phase / 2)
            0: begin
               tx_idle_pct = 25;
               rx_idle_pct = 85;
            end
            1: begin
               tx_idle_pct = 85;
               rx_idle_pct = 25;
            end
            default: begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
            end
         endcase
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (phase == 4 && n == ITEMS_PER_PHASE / 2) hold_request = 1'b1;
            if (phase == 2 && n == ITEMS_PER_PHASE / 2) begin
               req_ch.valid <= 1'b0;
               wait (reports_due == 0);
               @(negedge clock);
            end
            offer_random_item();
         end
      end

      req_ch.valid <= 1'b0;
      wait (reports_due == 0);
      repeat (250) @(negedge clock);
      if (mismatches == 0 && reports_due == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
